@@ design/kdt_pkg.sv @@
// Shared constants, types and command/status structs for the key debounce table.
package kdt_pkg;

   localparam int SLOT_COUNT = 32;
   localparam int KEY_BITS   = 9;
   localparam int TIMER_BITS = 8;
   localparam int ENTRY_W    = KEY_BITS + TIMER_BITS;
   localparam int ADDR_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [TIMER_BITS-1:0] DELAY_RESET = TIMER_BITS'(12);

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [0:0] REG_DELAY_IDX = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_rd;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic table_empty;
   } status_type;

endpackage

@@ design/kdt_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
module kdt_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/kdt_ctrl.sv @@
// Controller state machine that sequences the slot scan, update and result handshake.
module kdt_ctrl import kdt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.table_empty ? ST_UPDATE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.update   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ design/kdt_datapath.sv @@
// Datapath holding the slot RAM, scan counter, lookup trackers and result register.
module kdt_datapath import kdt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  req_opcode,
   input  logic [KEY_BITS-1:0]   req_key_code,
   input  logic                  req_press_edge,
   input  logic                  req_key_level,
   input  logic [TIMER_BITS-1:0] delay,
   output logic                  rsp_press_accepted
);

   logic                  op_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic                  edge_ff;
   logic                  level_ff;
   logic [CNT_W-1:0]      used_ff, used_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  rd_vld_ff;
   logic [ADDR_W-1:0]     rd_slot_ff;
   logic                  found_ff, found_in;
   logic [ADDR_W-1:0]     hit_slot_ff, hit_slot_in;
   logic [TIMER_BITS-1:0] hit_timer_ff, hit_timer_in;
   logic [ADDR_W-1:0]     min_slot_ff, min_slot_in;
   logic [TIMER_BITS-1:0] min_timer_ff, min_timer_in;
   logic                  press_ff;

   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ENTRY_W-1:0]    wr_data;
   logic [ENTRY_W-1:0]    rd_data;
   logic [KEY_BITS-1:0]   rd_key;
   logic [TIMER_BITS-1:0] rd_timer;
   logic                  has_room;
   logic [TIMER_BITS-1:0] cur_timer;
   logic [TIMER_BITS-1:0] new_timer;
   logic [ADDR_W-1:0]     upd_slot;
   logic                  accepted;

   kdt_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(SLOT_COUNT)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (cmd.scan_rd),
      .rd_addr(idx_ff[ADDR_W-1:0]),
      .rd_data(rd_data)
   );

   assign rd_key   = rd_data[ENTRY_W-1:TIMER_BITS];
   assign rd_timer = rd_data[TIMER_BITS-1:0];
   assign has_room = used_ff < CNT_W'(SLOT_COUNT);

   assign status.scan_last   = idx_ff == (used_ff - CNT_W'(1));
   assign status.table_empty = used_ff == '0;

   always_comb begin
      cur_timer = found_ff ? hit_timer_ff : '0;
      if (found_ff) begin
         upd_slot = hit_slot_ff;
      end else if (has_room) begin
         upd_slot = used_ff[ADDR_W-1:0];
      end else begin
         upd_slot = min_slot_ff;
      end
      accepted = (op_ff == OP_QUERY) && (cur_timer == '0) && edge_ff;
      if (accepted) begin
         new_timer = delay;
      end else if (!level_ff) begin
         new_timer = '0;
      end else begin
         new_timer = cur_timer;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_slot_ff;
      wr_data = {rd_key, rd_timer - TIMER_BITS'(1)};
      if (cmd.update) begin
         wr_en   = op_ff == OP_QUERY;
         wr_addr = upd_slot;
         wr_data = {key_ff, new_timer};
      end else if (rd_vld_ff && (op_ff == OP_TICK)) begin
         wr_en = rd_timer != '0;
      end
   end

   always_comb begin
      idx_in       = idx_ff;
      used_in      = used_ff;
      found_in     = found_ff;
      hit_slot_in  = hit_slot_ff;
      hit_timer_in = hit_timer_ff;
      min_slot_in  = min_slot_ff;
      min_timer_in = min_timer_ff;
      if (cmd.load) begin
         idx_in   = '0;
         found_in = 1'b0;
      end
      if (cmd.scan_rd) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (rd_vld_ff && (op_ff == OP_QUERY)) begin
         if (!found_ff && (rd_key == key_ff)) begin
            found_in     = 1'b1;
            hit_slot_in  = rd_slot_ff;
            hit_timer_in = rd_timer;
         end
         if ((rd_slot_ff == '0) || (rd_timer < min_timer_ff)) begin
            min_slot_in  = rd_slot_ff;
            min_timer_in = rd_timer;
         end
      end
      if (cmd.update && (op_ff == OP_QUERY) && !found_ff && has_room) begin
         used_in = used_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         idx_ff    <= '0;
         rd_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         used_ff   <= used_in;
         idx_ff    <= idx_in;
         rd_vld_ff <= cmd.scan_rd;
         found_ff  <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_opcode;
         key_ff   <= req_key_code;
         edge_ff  <= req_press_edge;
         level_ff <= req_key_level;
      end
      if (cmd.update) begin
         press_ff <= accepted;
      end
      rd_slot_ff   <= idx_ff[ADDR_W-1:0];
      hit_slot_ff  <= hit_slot_in;
      hit_timer_ff <= hit_timer_in;
      min_slot_ff  <= min_slot_in;
      min_timer_ff <= min_timer_in;
   end

   assign rsp_press_accepted = press_ff;

endmodule

@@ design/key_retrigger_debounce_table_top.sv @@
// Top level of the key re-trigger debounce table with its register port.
// Each transaction is accepted, then reads the slot RAM once per used slot of the 32
// through the single read port, drains the last read data and finally updates the
// slot and presents the result; when no slot is in use, the scan and drain are
// skipped. The update waits while an earlier result is still stalled. The next
// transaction is accepted once the update has been done, even while its result is
// still stalled.
module key_retrigger_debounce_table_top import kdt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [KEY_BITS-1:0]   req_key_code,
   input  logic                  req_press_edge,
   input  logic                  req_key_level,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_press_accepted,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cmd_type               cmd;
   status_type            status;
   logic [TIMER_BITS-1:0] delay_ff;
   logic                  delay_sel;

   assign csr_pready = 1'b1;
   assign delay_sel  = csr_paddr[CSR_ADDR_W-1:2] == REG_DELAY_IDX;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DELAY_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && delay_sel) begin
         delay_ff <= csr_pwdata[TIMER_BITS-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (delay_sel) begin
         csr_prdata = CSR_DATA_W'(delay_ff);
      end
   end

   kdt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status   (status),
      .cmd      (cmd)
   );

   kdt_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_opcode),
      .req_key_code      (req_key_code),
      .req_press_edge    (req_press_edge),
      .req_key_level     (req_key_level),
      .delay             (delay_ff),
      .rsp_press_accepted(rsp_press_accepted)
   );

endmodule

@@ sim/tb_key_retrigger_debounce_table_top.sv @@
// Self-checking testbench for the key re-trigger debounce table top level.
module tb_key_retrigger_debounce_table_top import kdt_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_ADDR_W-1:0] DELAY_ADDR = CSR_ADDR_W'({REG_DELAY_IDX, 2'b00});
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = CSR_ADDR_W'(4);
   localparam int KEY_POOL   = 40;
   localparam int SETTLE     = 40;
   localparam int HOLD_SPAN  = 400;

   typedef struct packed {
      logic                opcode;
      logic [KEY_BITS-1:0] key_code;
      logic                press_edge;
      logic                key_level;
   } key_req_type;

   class press_scoreboard;
      logic [KEY_BITS-1:0]   tracked_key [SLOT_COUNT];
      logic [TIMER_BITS-1:0] frames_left [SLOT_COUNT];
      int unsigned           keys_tracked;
      logic [TIMER_BITS-1:0] delay_frames;
      logic                  expected_press_q [$];
      int unsigned           failures;

      function new();
         for (int i = 0; i < SLOT_COUNT; i++) begin
            tracked_key[i] = '0;
            frames_left[i] = '0;
         end
         keys_tracked = 0;
         delay_frames = DELAY_RESET;
         failures = 0;
      endfunction

      function int unsigned slot_for_key(logic [KEY_BITS-1:0] key);
         int unsigned victim;
         for (int i = 0; i < keys_tracked; i++) begin
            if (tracked_key[i] == key) return i;
         end
         if (keys_tracked < SLOT_COUNT) begin
            tracked_key[keys_tracked] = key;
            frames_left[keys_tracked] = '0;
            keys_tracked++;
            return keys_tracked - 1;
         end
         victim = 0;
         for (int i = 1; i < SLOT_COUNT; i++) begin
            if (frames_left[i] < frames_left[victim]) victim = i;
         end
         tracked_key[victim] = key;
         frames_left[victim] = '0;
         return victim;
      endfunction

      function void record_request(key_req_type r);
         int unsigned slot;
         logic        accepted;
         accepted = 1'b0;
         if (r.opcode == OP_TICK) begin
            for (int i = 0; i < keys_tracked; i++) begin
               if (frames_left[i] != 0) frames_left[i] = frames_left[i] - 1'b1;
            end
         end else begin
            slot = slot_for_key(r.key_code);
            if (frames_left[slot] == 0 && r.press_edge) begin
               frames_left[slot] = delay_frames;
               accepted = 1'b1;
            end else if (!r.key_level) begin
               frames_left[slot] = '0;
            end
         end
         expected_press_q.push_back(accepted);
      endfunction

      function void check_response(logic got);
         logic want;
         if (expected_press_q.size() == 0) begin
            failures++;
            $display("%0t: unexpected transaction, expected none, actual press_accepted %0b",
                     $time, got);
         end else begin
            want = expected_press_q.pop_front();
            if (got !== want) begin
               failures++;
               $display("%0t: press_accepted expected %0b actual %0b", $time, want, got);
            end
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_opcode = OP_TICK;
   logic [KEY_BITS-1:0]   req_key_code = '0;
   logic                  req_press_edge = 1'b0;
   logic                  req_key_level = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_press_accepted;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   press_scoreboard press_check = new();
   bit              pressure_go = 1'b0;
   int unsigned     burst_left = 1;

   key_retrigger_debounce_table_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("key_retrigger_debounce_table_top: mismatch");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) press_check.check_response(rsp_press_accepted);
   end

   initial begin : receiver
      int unsigned mode;
      int unsigned span;
      int unsigned held;
      bit          hold_done;
      hold_done = 1'b0;
      forever begin
         if (pressure_go && !hold_done) begin
            hold_done = 1'b1;
            held = 0;
            rsp_stall <= 1'b1;
            while (held < HOLD_SPAN) begin
               @(posedge clock);
               held++;
            end
         end
         mode = $urandom_range(0, 2);
         span = $urandom_range(10, 60);
         repeat (span) begin
            case (mode)
               0: begin
                  rsp_stall <= 1'b0;
               end
               1: begin
                  rsp_stall <= ($urandom_range(0, 2) == 0);
               end
               default: begin
                  rsp_stall <= ($urandom_range(0, 3) != 0);
               end
            endcase
            @(posedge clock);
         end
      end
   end

   task automatic send_request(key_req_type r);
      int unsigned gap;
      req_valid      <= 1'b1;
      req_opcode     <= r.opcode;
      req_key_code   <= r.key_code;
      req_press_edge <= r.press_edge;
      req_key_level  <= r.key_level;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      press_check.record_request(r);
      burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic offer(logic op, logic [KEY_BITS-1:0] key, logic pe, logic lvl);
      key_req_type r;
      r.opcode     = op;
      r.key_code   = key;
      r.press_edge = pe;
      r.key_level  = lvl;
      send_request(r);
   endtask

   function automatic key_req_type random_request();
      key_req_type r;
      int unsigned pick;
      r.key_code = KEY_BITS'($urandom_range(0, KEY_POOL - 1) * 97 + 5);
      if ($urandom_range(0, 9) == 0) r.key_code = KEY_BITS'($urandom_range(0, (1 << KEY_BITS) - 1));
      if ($urandom_range(0, 3) == 0) begin
         r.opcode     = OP_TICK;
         r.press_edge = 1'($urandom_range(0, 1));
         r.key_level  = 1'($urandom_range(0, 1));
      end else begin
         r.opcode = OP_QUERY;
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            r.press_edge = 1'b1;
            r.key_level  = 1'b1;
         end else if (pick < 80) begin
            r.press_edge = 1'b0;
            r.key_level  = 1'b1;
         end else if (pick < 95) begin
            r.press_edge = 1'b0;
            r.key_level  = 1'b0;
         end else begin
            r.press_edge = 1'b1;
            r.key_level  = 1'b0;
         end
      end
      return r;
   endfunction

   task automatic run_random(int unsigned count);
      repeat (count) send_request(random_request());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (press_check.expected_press_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == DELAY_ADDR) press_check.delay_frames = data[TIMER_BITS-1:0];
   endtask

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] noise;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer(OP_TICK,  '1,  1'b1, 1'b1);
      offer(OP_QUERY, '0,  1'b1, 1'b1);
      offer(OP_QUERY, '0,  1'b1, 1'b1);
      offer(OP_QUERY, '0,  1'b0, 1'b1);
      offer(OP_QUERY, '0,  1'b1, 1'b0);
      offer(OP_QUERY, '0,  1'b1, 1'b1);
      offer(OP_QUERY, '1,  1'b0, 1'b0);
      offer(OP_QUERY, '1,  1'b1, 1'b1);
      offer(OP_TICK,  '0,  1'b0, 1'b0);
      offer(OP_QUERY, '1,  1'b0, 1'b1);
      offer(OP_QUERY, '1,  1'b1, 1'b1);
      offer(OP_QUERY, '1,  1'b0, 1'b0);
      offer(OP_QUERY, '1,  1'b1, 1'b1);
      offer(OP_QUERY, 9'h155, 1'b1, 1'b1);
      offer(OP_QUERY, 9'h0AA, 1'b1, 1'b1);
      offer(OP_TICK,  9'h0AA, 1'b1, 1'b0);
      offer(OP_QUERY, 9'h155, 1'b1, 1'b0);
      offer(OP_QUERY, 9'h155, 1'b1, 1'b1);
      wait_drained();

      csr_write(SPARE_ADDR, '1);
      csr_write(DELAY_ADDR, 32'd3);
      pressure_go = 1'b1;
      run_random(100);
      wait_drained();

      csr_write(DELAY_ADDR, 32'd0);
      run_random(80);
      wait_drained();

      csr_write(DELAY_ADDR, 32'hABCD_12FF);
      run_random(80);
      wait_drained();

      csr_write(DELAY_ADDR, 32'd1);
      run_random(110);
      wait_drained();

      noise = $urandom();
      csr_write(DELAY_ADDR, noise);
      run_random(110);
      wait_drained();

      if (press_check.failures == 0 && press_check.expected_press_q.size() == 0) begin
         $display("key_retrigger_debounce_table_top: match");
      end else begin
         $display("key_retrigger_debounce_table_top: mismatch");
      end
      $finish;
   end

endmodule

@@ key_retrigger_debounce_table_top.f @@
design/kdt_pkg.sv
design/kdt_ram.sv
design/kdt_ctrl.sv
design/kdt_datapath.sv
design/key_retrigger_debounce_table_top.sv
sim/tb_key_retrigger_debounce_table_top.sv
